### src/lambda_text_tokenizer_top_macros.svh
// Assertion macros for the lambda text tokenizer.
// Used by lambda_text_tokenizer_top; expects clk and rst_n in scope.
`ifndef LAMBDA_TEXT_TOKENIZER_TOP_MACROS_SVH
`define LAMBDA_TEXT_TOKENIZER_TOP_MACROS_SVH

// cond holds now implies prop holds in the same cycle
`define LTT_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond holds now implies prop holds in the next cycle
`define LTT_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/ltt_pkg.sv
// Types and constants shared by the lambda text tokenizer modules.
// No dependencies.
package ltt_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [31:0] line_number;
        logic [31:0] token_column;
        logic        quote_error;
        logic        last_of_text;
    } out_item_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NAME,
        MODE_COMMENT,
        MODE_QUOTE
    } mode_t;

    typedef enum logic [3:0] {
        KIND_DECL    = 4'd0,
        KIND_SYMBOL  = 4'd1,
        KIND_OPEN    = 4'd2,
        KIND_CLOSE   = 4'd3,
        KIND_SPACE   = 4'd4,
        KIND_NEWLINE = 4'd5,
        KIND_COMMENT = 4'd6,
        KIND_QUOTE   = 4'd7,
        KIND_NAME    = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        REG_DECL_BYTES,
        REG_DECL_LEN,
        REG_SYM_BYTES,
        REG_SYM_LEN
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] decl_bytes;
        logic [3:0]  decl_len;
        logic [63:0] sym_bytes;
        logic [3:0]  sym_len;
    } kw_cfg_t;

    // core -> output stage
    typedef struct packed {
        logic emit;       // new result in res
        logic hold;       // keep it back until the next result or end of text
        logic mark_last;  // text ended with no result of its own
    } res_ctl_t;

    localparam int          KW_MAX_BYTES = 8;
    localparam logic [31:0] SAT32        = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

### src/ltt_cfg.sv
// APB-style register file holding the two keyword strings and lengths.
// Depends on ltt_pkg.
module ltt_cfg
    import ltt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output kw_cfg_t     cfg
);

    kw_cfg_t  cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DECL_BYTES: cfg_reg.decl_bytes <= pwdata;
                REG_DECL_LEN:   cfg_reg.decl_len   <= pwdata[3:0];
                REG_SYM_BYTES:  cfg_reg.sym_bytes  <= pwdata;
                REG_SYM_LEN:    cfg_reg.sym_len    <= pwdata[3:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DECL_BYTES: prdata = cfg_reg.decl_bytes;
            REG_DECL_LEN:   prdata = {60'd0, cfg_reg.decl_len};
            REG_SYM_BYTES:  prdata = cfg_reg.sym_bytes;
            REG_SYM_LEN:    prdata = {60'd0, cfg_reg.sym_len};
            default:        prdata = '0;
        endcase
    end

endmodule

### src/ltt_core.sv
// Lookahead window, token classifier and per-step token state.
// Depends on ltt_pkg.
module ltt_core
    import ltt_pkg::*;
#(
    parameter int MAX_KEYWORD   = 8,
    parameter int POSITION_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  kw_cfg_t   cfg,
    input  logic      text_valid,
    input  in_item_t  text_item,
    output logic      text_stall,
    input  logic      s_free,
    output res_ctl_t  ctl,
    output out_item_t res
);

    localparam int WIN    = (MAX_KEYWORD < 2) ? 2 : MAX_KEYWORD;
    localparam int KW_CAP = (MAX_KEYWORD < KW_MAX_BYTES) ? MAX_KEYWORD : KW_MAX_BYTES;
    localparam int FILL_W = $clog2(WIN + 1);
    localparam int PB     = POSITION_BITS;

    logic [8*WIN-1:0]  win_reg, win_next;
    logic [FILL_W-1:0] fill_reg;
    mode_t             mode_reg, mode_next;
    logic              esc_reg, drain_reg;
    logic [PB-1:0]     pstart_reg, pos_reg;
    logic [31:0]       plen_reg, line_reg, col_reg;

    logic [7:0]        c, d;
    logic              two, decl_hit, sym_hit;
    logic [3:0]        cls_kind;
    logic [FILL_W-1:0] cls_len;

    logic              dec_go, flush_go, fire, flush_fire, flush_res;
    logic              want_emit, esc_n, push;
    logic [3:0]        e_kind;
    logic [31:0]       e_start, e_len, grow_len, plen_n;
    logic [PB-1:0]     pstart_n;
    logic [FILL_W-1:0] pop, fill_after;

    assign c   = win_reg[7:0];
    assign d   = win_reg[15:8];
    assign two = fill_reg >= FILL_W'(2);

    // keyword compare against the head of the window
    always_comb
    begin
        decl_hit = (cfg.decl_len != 4'd0) && (32'(cfg.decl_len) <= KW_CAP)
                && (32'(cfg.decl_len) <= 32'(fill_reg));
        sym_hit  = (cfg.sym_len != 4'd0) && (32'(cfg.sym_len) <= KW_CAP)
                && (32'(cfg.sym_len) <= 32'(fill_reg));
        for (int k = 0; k < KW_CAP; k++)
        begin
            if (k < 32'(cfg.decl_len) && win_reg[8*k +: 8] != cfg.decl_bytes[8*k +: 8])
                decl_hit = 1'b0;
            if (k < 32'(cfg.sym_len) && win_reg[8*k +: 8] != cfg.sym_bytes[8*k +: 8])
                sym_hit = 1'b0;
        end
    end

    always_comb
    begin
        cls_len = FILL_W'(1);
        priority if (decl_hit)
        begin
            cls_kind = KIND_DECL;
            cls_len  = FILL_W'(cfg.decl_len);
        end
        else if (sym_hit)
        begin
            cls_kind = KIND_SYMBOL;
            cls_len  = FILL_W'(cfg.sym_len);
        end
        else if (c == CH_OPEN)                    cls_kind = KIND_OPEN;
        else if (c == CH_CLOSE)                   cls_kind = KIND_CLOSE;
        else if (c == CH_SPACE || c == CH_TAB)    cls_kind = KIND_SPACE;
        else if (two && ((c == CH_CR && d == CH_LF) || (c == CH_LF && d == CH_CR)))
        begin
            cls_kind = KIND_NEWLINE;
            cls_len  = FILL_W'(2);
        end
        else if (c == CH_LF)                      cls_kind = KIND_NEWLINE;
        else if (c == CH_HASH || c == CH_SEMI)    cls_kind = KIND_COMMENT;
        else if (c == CH_QUOTE)                   cls_kind = KIND_QUOTE;
        else                                      cls_kind = KIND_NAME;
    end

    assign grow_len = (plen_reg == SAT32) ? plen_reg : plen_reg + 32'd1;

    // mode transition of one decide step
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_NAME:    if (cls_kind != KIND_NAME) mode_next = MODE_IDLE;
            MODE_COMMENT: if (c == CH_LF) mode_next = MODE_IDLE;
            MODE_QUOTE:   if (c == CH_QUOTE && !esc_reg) mode_next = MODE_IDLE;
            MODE_IDLE:
            begin
                if (cls_kind == KIND_COMMENT)    mode_next = MODE_COMMENT;
                else if (cls_kind == KIND_QUOTE) mode_next = MODE_QUOTE;
                else if (cls_kind == KIND_NAME)  mode_next = MODE_NAME;
            end
            default:      mode_next = MODE_IDLE;
        endcase
    end

    // datapath of one decide step
    always_comb
    begin
        want_emit = 1'b0;
        e_kind    = KIND_NAME;
        e_start   = 32'(pstart_reg);
        e_len     = plen_reg;
        pop       = '0;
        esc_n     = esc_reg;
        pstart_n  = pstart_reg;
        plen_n    = plen_reg;
        unique case (mode_reg)
            MODE_NAME:
            begin
                if (cls_kind != KIND_NAME)
                    want_emit = 1'b1;
                else
                begin
                    plen_n = grow_len;
                    pop    = FILL_W'(1);
                end
            end
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                begin
                    want_emit = 1'b1;
                    e_kind    = KIND_COMMENT;
                end
                else
                begin
                    plen_n = grow_len;
                    pop    = FILL_W'(1);
                end
            end
            MODE_QUOTE:
            begin
                pop    = FILL_W'(1);
                plen_n = grow_len;
                if (c == CH_QUOTE && !esc_reg)
                begin
                    want_emit = 1'b1;
                    e_kind    = KIND_QUOTE;
                    e_len     = grow_len;
                end
                else
                    esc_n = (c == CH_BSLASH) ? !esc_reg : 1'b0;
            end
            default:
            begin
                if (cls_kind <= KIND_NEWLINE)
                begin
                    want_emit = 1'b1;
                    e_kind    = cls_kind;
                    e_start   = 32'(pos_reg);
                    e_len     = 32'(cls_len);
                    pop       = cls_len;
                end
                else
                begin
                    pstart_n = pos_reg;
                    plen_n   = 32'd1;
                    esc_n    = 1'b0;
                    pop      = FILL_W'(1);
                end
            end
        endcase
    end

    assign dec_go     = (fill_reg == FILL_W'(WIN)) || (drain_reg && fill_reg != '0);
    assign flush_go   = drain_reg && fill_reg == '0;
    assign flush_res  = mode_reg != MODE_IDLE;
    assign fire       = dec_go && (!want_emit || s_free);
    assign flush_fire = flush_go && (!flush_res || s_free);

    assign text_stall = drain_reg
                     || (fill_reg == FILL_W'(WIN) && !(fire && pop != '0));
    assign push       = text_valid && !text_stall;
    assign fill_after = fire ? fill_reg - pop : fill_reg;

    always_comb
    begin
        win_next = win_reg;
        if (fire)
            win_next = win_reg >> {pop, 3'b000};
        for (int i = 0; i < WIN; i++)
        begin
            if (push && FILL_W'(i) == fill_after)
                win_next[8*i +: 8] = text_item.text_byte;
        end
    end

    always_comb
    begin
        ctl.emit      = (fire && want_emit) || (flush_fire && flush_res);
        ctl.hold      = drain_reg && !flush_go;
        ctl.mark_last = flush_fire && !flush_res;
        res.token_kind   = e_kind;
        res.token_start  = e_start;
        res.token_length = e_len;
        res.line_number  = line_reg;
        res.token_column = col_reg;
        res.quote_error  = 1'b0;
        res.last_of_text = 1'b0;
        if (flush_go)
        begin
            res.last_of_text = 1'b1;
            res.token_start  = 32'(pstart_reg);
            res.token_length = plen_reg;
            unique case (mode_reg)
                MODE_COMMENT: res.token_kind = KIND_COMMENT;
                MODE_QUOTE:
                begin
                    res.token_kind   = KIND_DECL;
                    res.token_start  = '0;
                    res.token_length = '0;
                    res.line_number  = '0;
                    res.token_column = '0;
                    res.quote_error  = 1'b1;
                end
                default:      res.token_kind = KIND_NAME;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            mode_reg   <= MODE_IDLE;
            esc_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            pos_reg    <= '0;
            line_reg   <= 32'd1;
            col_reg    <= 32'd1;
        end
        else if (flush_fire)
        begin
            fill_reg   <= '0;
            mode_reg   <= MODE_IDLE;
            esc_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            pos_reg    <= '0;
            line_reg   <= 32'd1;
            col_reg    <= 32'd1;
        end
        else
        begin
            if (fire)
            begin
                mode_reg   <= mode_next;
                esc_reg    <= esc_n;
                pstart_reg <= pstart_n;
                plen_reg   <= plen_n;
                pos_reg    <= pos_reg + PB'(pop);
                if (want_emit)
                begin
                    if (e_kind == KIND_NEWLINE)
                    begin
                        if (line_reg != SAT32)
                            line_reg <= line_reg + 32'd1;
                        col_reg <= 32'd1;
                    end
                    else if (col_reg != SAT32)
                        col_reg <= col_reg + 32'd1;
                end
            end
            fill_reg <= fill_after + FILL_W'(push);
            if (push && text_item.end_of_text)
                drain_reg <= 1'b1;
        end
    end

endmodule

### src/ltt_out.sv
// Two-entry result path: a staging slot that can hold back the newest
// result until the end of text is known, and the output register.
// Depends on ltt_pkg.
module ltt_out
    import ltt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_ctl_t  ctl,
    input  out_item_t res,
    output logic      s_free,
    output logic      tok_valid,
    input  logic      tok_stall,
    output out_item_t tok_item
);

    out_item_t s_item_reg, o_item_reg;
    logic      s_valid_reg, s_hold_reg, o_valid_reg;
    logic      o_can_take, s_move;

    assign o_can_take = !o_valid_reg || !tok_stall;
    assign s_free     = !s_valid_reg || o_can_take;
    assign s_move     = s_valid_reg && o_can_take && (!s_hold_reg || ctl.emit);

    assign tok_valid = o_valid_reg;
    assign tok_item  = o_item_reg;

    always_ff @(posedge clk)
    begin
        if (s_move)
            o_item_reg <= s_item_reg;
        if (ctl.emit)
            s_item_reg <= res;
        else if (ctl.mark_last)
            s_item_reg.last_of_text <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            s_hold_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_move)
                o_valid_reg <= 1'b1;
            else if (!tok_stall)
                o_valid_reg <= 1'b0;
            if (ctl.emit)
            begin
                s_valid_reg <= 1'b1;
                s_hold_reg  <= ctl.hold;
            end
            else
            begin
                if (s_move)
                    s_valid_reg <= 1'b0;
                if (ctl.mark_last)
                    s_hold_reg <= 1'b0;
            end
        end
    end

endmodule

### src/lambda_text_tokenizer_top.sv
// Top level of the lambda text tokenizer: config port, core, result path.
// Depends on ltt_pkg, ltt_cfg, ltt_core, ltt_out and the macros header.
//
// Usage:
//  - Text enters one byte per transaction on text_valid/text_stall with
//    text_item; end_of_text marks the last byte of a text.
//  - Tokens leave on tok_valid/tok_stall with tok_item, one per transaction.
//  - Keywords are set over the APB port (64-bit registers at 8*i) while idle.
// Timing:
//  - A byte is held in a lookahead window of MAX_KEYWORD (at least two)
//    bytes; the head is decided once the window is full, and a decided
//    token then passes through the staging slot and the output register.
//  - Sustained rate is one byte per cycle while results are accepted;
//    each name or comment end adds a decide step that consumes nothing.
//  - At end of text the window drains one decide step per cycle while
//    results are accepted (one per other token or name/comment/quote byte,
//    plus one per name or comment end), one flush step; input stalls meanwhile.
//  - Results decided while draining wait in a staging slot so that the
//    final one can carry last_of_text.
// Reset clears all text state; line and column restart at one. When
// tok_stall is high the output register and staging slot hold; once both
// are full and the core has a result to place, the core stalls, and
// text_stall rises as soon as the window is full.
`include "lambda_text_tokenizer_top_macros.svh"
module lambda_text_tokenizer_top
    import ltt_pkg::*;
#(
    parameter int MAX_KEYWORD   = 8,
    parameter int POSITION_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        text_valid,
    output logic        text_stall,
    input  in_item_t    text_item,
    output logic        tok_valid,
    input  logic        tok_stall,
    output out_item_t   tok_item
);

    kw_cfg_t   cfg;
    res_ctl_t  ctl;
    out_item_t res;
    logic      s_free;

    ltt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // window, classification and token state
    ltt_core #(
        .MAX_KEYWORD   (MAX_KEYWORD),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text_valid (text_valid),
        .text_item  (text_item),
        .text_stall (text_stall),
        .s_free     (s_free),
        .ctl        (ctl),
        .res        (res)
    );

    // staging slot plus output register
    ltt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .res       (res),
        .s_free    (s_free),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    // an unterminated quote is always the final result of its text
    `LTT_ASSERT_NOW(a_err_is_last, tok_valid && tok_item.quote_error, tok_item.last_of_text && tok_item.token_kind == KIND_DECL, "quote error result not last or kind nonzero")

    // the end of a text always starts a drain, which blocks input
    `LTT_ASSERT_NEXT(a_end_drains, text_valid && !text_stall && text_item.end_of_text, text_stall, "input taken right after end of text")

    // line and column start at one and saturate
    `LTT_ASSERT_NOW(a_pos_nonzero, tok_valid && !tok_item.quote_error, tok_item.line_number != 32'd0 && tok_item.token_column != 32'd0, "zero line or column on a token")

endmodule
